@@ src/tcw_pkg.sv @@
// Package for the text console writer: screen geometry, cell codes and the
// types shared by the top level, the controller and the datapath.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

	// Screen geometry
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;

	// Cell index widths: ADDR_W indexes the store, NXT_W also holds CELLS
	localparam int ADDR_W = $clog2(CELLS);
	localparam int NXT_W  = $clog2(CELLS + 1);
	localparam int POS_W  = 11;
	localparam int CMP_W  = (POS_W > NXT_W) ? POS_W : NXT_W;

	// Character and attribute codes
	localparam logic [7:0] SPACE_CHAR     = 8'h20;
	localparam logic [7:0] NEWLINE_CHAR   = 8'h0a;
	localparam logic [7:0] BACKSPACE_CHAR = 8'h08;
	localparam logic [7:0] RESET_ATTR     = 8'h0f;

	typedef enum logic [2:0] {
		K_PRINT    = 3'd0,
		K_PRINT_AT = 3'd1,
		K_SET      = 3'd2,
		K_CLEAR    = 3'd3,
		K_READ     = 3'd4
	} kind_t;

	typedef struct packed {
		logic [2:0]       kind;
		logic [7:0]       char_code;
		logic [POS_W-1:0] position;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0] cursor_pos;
		logic [7:0]       read_char;
		logic [7:0]       read_attr;
	} out_item_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_EXEC,
		S_ROW,
		S_SCROLL,
		S_FILL,
		S_CLEAR,
		S_READ,
		S_DONE
	} state_t;

	// Next-cursor selection
	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_INC,
		CUR_BACK,
		CUR_LINE,
		CUR_POS,
		CUR_ZERO
	} cur_op_t;

	// Sweep write source for the delayed write stage
	typedef enum logic [1:0] {
		SW_NONE,
		SW_COPY,
		SW_BLANK,
		SW_INIT
	} sweep_t;

	typedef struct packed {
		logic    cap;        // latch the input item
		logic    wr_char;    // write printed char at base cell
		cur_op_t cur_op;
		logic    row_clr;
		logic    row_step;
		logic    idx_clr;
		logic    idx_row;    // idx to start of bottom row
		logic    idx_inc;
		sweep_t  sweep;
		logic    rd_en;
		logic    rd_copy;    // read address from sweep index
		logic    out_load;
		logic    out_rd;     // result carries read data
	} ctl_cmd_t;

	typedef struct packed {
		logic [2:0] kind;
		logic       is_nl;
		logic       is_bs;
		logic       inc_wrap;
		logic       line_wrap;
		logic       row_done;
		logic       idx_last_copy;
		logic       idx_last_cell;
		logic       out_free;
	} ctl_stat_t;

endpackage

`default_nettype wire

@@ src/tcw_ctrl.sv @@
// Controller state machine for the text console writer.
// Depends on tcw_pkg; drives tcw_datapath through ctl_cmd_t.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tcw_pkg::ctl_stat_t stat,
	output tcw_pkg::ctl_cmd_t  cmd
);

	tcw_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcw_pkg::S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcw_pkg::S_INIT: begin
				if (stat.idx_last_cell) state_d = tcw_pkg::S_IDLE;
			end
			tcw_pkg::S_IDLE: begin
				if (in_valid) state_d = tcw_pkg::S_EXEC;
			end
			tcw_pkg::S_EXEC: begin
				case (stat.kind)
					tcw_pkg::K_PRINT, tcw_pkg::K_PRINT_AT: begin
						if (stat.is_nl) begin
							state_d = tcw_pkg::S_ROW;
						end else if (!stat.is_bs && stat.inc_wrap) begin
							state_d = tcw_pkg::S_SCROLL;
						end else if (stat.out_free) begin
							state_d = tcw_pkg::S_IDLE;
						end else begin
							state_d = tcw_pkg::S_DONE;
						end
					end
					tcw_pkg::K_CLEAR: state_d = tcw_pkg::S_CLEAR;
					tcw_pkg::K_READ:  state_d = tcw_pkg::S_READ;
					default: begin
						state_d = stat.out_free ? tcw_pkg::S_IDLE : tcw_pkg::S_DONE;
					end
				endcase
			end
			tcw_pkg::S_ROW: begin
				if (stat.row_done) begin
					state_d = stat.line_wrap ? tcw_pkg::S_SCROLL : tcw_pkg::S_DONE;
				end
			end
			tcw_pkg::S_SCROLL: begin
				if (stat.idx_last_copy) state_d = tcw_pkg::S_FILL;
			end
			tcw_pkg::S_FILL, tcw_pkg::S_CLEAR: begin
				if (stat.idx_last_cell) state_d = tcw_pkg::S_DONE;
			end
			tcw_pkg::S_READ, tcw_pkg::S_DONE: begin
				if (stat.out_free) state_d = tcw_pkg::S_IDLE;
			end
			default: state_d = tcw_pkg::S_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		in_ready     = 1'b0;
		cmd          = '0;
		cmd.cur_op   = tcw_pkg::CUR_HOLD;
		cmd.sweep    = tcw_pkg::SW_NONE;
		case (state_q)
			tcw_pkg::S_INIT: begin
				cmd.sweep   = tcw_pkg::SW_INIT;
				cmd.idx_inc = 1'b1;
			end
			tcw_pkg::S_IDLE: begin
				in_ready = 1'b1;
				cmd.cap  = in_valid;
			end
			tcw_pkg::S_EXEC: begin
				case (stat.kind)
					tcw_pkg::K_PRINT, tcw_pkg::K_PRINT_AT: begin
						if (stat.is_nl) begin
							cmd.row_clr = 1'b1;
						end else if (stat.is_bs) begin
							cmd.cur_op   = tcw_pkg::CUR_BACK;
							cmd.out_load = stat.out_free;
						end else begin
							cmd.wr_char  = 1'b1;
							cmd.cur_op   = tcw_pkg::CUR_INC;
							cmd.idx_clr  = stat.inc_wrap;
							cmd.out_load = stat.out_free && !stat.inc_wrap;
						end
					end
					tcw_pkg::K_SET: begin
						cmd.cur_op   = tcw_pkg::CUR_POS;
						cmd.out_load = stat.out_free;
					end
					tcw_pkg::K_CLEAR: begin
						cmd.cur_op  = tcw_pkg::CUR_ZERO;
						cmd.idx_clr = 1'b1;
					end
					tcw_pkg::K_READ: begin
						cmd.rd_en = 1'b1;
					end
					default: begin
						cmd.out_load = stat.out_free;
					end
				endcase
			end
			tcw_pkg::S_ROW: begin
				if (stat.row_done) begin
					cmd.cur_op  = tcw_pkg::CUR_LINE;
					cmd.idx_clr = stat.line_wrap;
				end else begin
					cmd.row_step = 1'b1;
				end
			end
			tcw_pkg::S_SCROLL: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_copy = 1'b1;
				cmd.sweep   = tcw_pkg::SW_COPY;
				cmd.idx_inc = !stat.idx_last_copy;
				cmd.idx_row = stat.idx_last_copy;
			end
			tcw_pkg::S_FILL, tcw_pkg::S_CLEAR: begin
				cmd.sweep   = tcw_pkg::SW_BLANK;
				cmd.idx_inc = 1'b1;
			end
			tcw_pkg::S_READ: begin
				cmd.out_load = stat.out_free;
				cmd.out_rd   = 1'b1;
			end
			tcw_pkg::S_DONE: begin
				cmd.out_load = stat.out_free;
			end
			default: begin
				cmd.cur_op = tcw_pkg::CUR_HOLD;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ src/tcw_datapath.sv @@
// Datapath for the text console writer: screen store, cursor, row search,
// sweep counter with delayed write stage, attribute and result registers.
// Depends on tcw_pkg; steered by tcw_ctrl.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire tcw_pkg::ctl_cmd_t cmd,
	output tcw_pkg::ctl_stat_t  stat,
	input  wire tcw_pkg::in_item_t in_data,
	input  wire logic           cfg_wr_en,
	input  wire logic [7:0]     cfg_wr_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output tcw_pkg::out_item_t  out_data
);

	localparam int AW = tcw_pkg::ADDR_W;
	localparam int NW = tcw_pkg::NXT_W;
	localparam int CW = tcw_pkg::CMP_W;

	logic [15:0] mem [tcw_pkg::CELLS];

	logic [7:0]    attr_q;
	logic [2:0]    kind_q;
	logic [7:0]    char_q;
	logic [AW-1:0] pos_q;
	logic [AW-1:0] base_q;
	logic [AW-1:0] cur_q, cur_d;
	logic [NW-1:0] acc_q;
	logic [AW-1:0] idx_q;
	logic [15:0]   rdata_q;

	// Delayed sweep write stage
	logic          wv_s1;
	logic          wcopy_s1;
	logic [AW-1:0] wa_s1;
	logic [15:0]   wd_s1;

	logic                 out_valid_q;
	tcw_pkg::out_item_t   out_q;

	logic [AW-1:0] pos_clamp;
	logic [NW-1:0] inc_w, line_w;
	logic          inc_wrap, line_wrap;
	logic          mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	logic [15:0]   mem_wd;

	assign pos_clamp = (CW'(in_data.position) >= CW'(tcw_pkg::CELLS))
		? AW'(tcw_pkg::CELLS - 1) : AW'(in_data.position);

	assign inc_w     = NW'(base_q) + NW'(1);
	assign line_w    = acc_q + NW'(tcw_pkg::COLUMNS);
	assign inc_wrap  = inc_w >= NW'(tcw_pkg::CELLS);
	assign line_wrap = line_w >= NW'(tcw_pkg::CELLS);

	always_comb begin
		case (cmd.cur_op)
			tcw_pkg::CUR_INC:  cur_d = inc_wrap ? AW'(inc_w - NW'(tcw_pkg::COLUMNS)) : AW'(inc_w);
			tcw_pkg::CUR_BACK: cur_d = (base_q == '0) ? '0 : base_q - AW'(1);
			tcw_pkg::CUR_LINE: cur_d = line_wrap ? AW'(acc_q) : AW'(line_w);
			tcw_pkg::CUR_POS:  cur_d = pos_q;
			tcw_pkg::CUR_ZERO: cur_d = '0;
			default:           cur_d = cur_q;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		stat.kind          = kind_q;
		stat.is_nl         = char_q == tcw_pkg::NEWLINE_CHAR;
		stat.is_bs         = char_q == tcw_pkg::BACKSPACE_CHAR;
		stat.inc_wrap      = inc_wrap;
		stat.line_wrap     = line_wrap;
		stat.row_done      = line_w > NW'(base_q);
		stat.idx_last_copy = idx_q == AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS - 1);
		stat.idx_last_cell = idx_q == AW'(tcw_pkg::CELLS - 1);
		stat.out_free      = !out_valid_q || out_ready;
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q      <= tcw_pkg::RESET_ATTR;
			cur_q       <= '0;
			idx_q       <= '0;
			wv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) attr_q <= cfg_wr_data;
			cur_q <= cur_d;
			if (cmd.idx_clr) begin
				idx_q <= '0;
			end else if (cmd.idx_row) begin
				idx_q <= AW'(tcw_pkg::CELLS - tcw_pkg::COLUMNS);
			end else if (cmd.idx_inc) begin
				idx_q <= idx_q + AW'(1);
			end
			wv_s1 <= cmd.sweep != tcw_pkg::SW_NONE;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q <= in_data.kind;
			char_q <= in_data.char_code;
			pos_q  <= pos_clamp;
			base_q <= (in_data.kind == tcw_pkg::K_PRINT_AT) ? pos_clamp : cur_q;
		end
		if (cmd.row_clr) begin
			acc_q <= '0;
		end else if (cmd.row_step) begin
			acc_q <= line_w;
		end
		wa_s1    <= idx_q;
		wcopy_s1 <= cmd.sweep == tcw_pkg::SW_COPY;
		wd_s1    <= {(cmd.sweep == tcw_pkg::SW_INIT) ? tcw_pkg::RESET_ATTR : attr_q,
			tcw_pkg::SPACE_CHAR};
		if (cmd.out_load) begin
			out_q.cursor_pos <= tcw_pkg::POS_W'(cur_d);
			out_q.read_char  <= cmd.out_rd ? rdata_q[7:0] : 8'd0;
			out_q.read_attr  <= cmd.out_rd ? rdata_q[15:8] : 8'd0;
		end
	end

	// Screen store: one write port, one registered read port
	always_comb begin
		mem_we = wv_s1 || cmd.wr_char;
		mem_wa = wv_s1 ? wa_s1 : base_q;
		if (wv_s1) begin
			mem_wd = wcopy_s1 ? rdata_q : wd_s1;
		end else begin
			mem_wd = {attr_q, char_q};
		end
		mem_ra = cmd.rd_copy ? idx_q + AW'(tcw_pkg::COLUMNS) : pos_q;
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (cmd.rd_en) rdata_q <= mem[mem_ra];
	end

endmodule

`default_nettype wire

@@ src/text_console_writer.sv @@
// Top level of the text console writer: 80x25 character/attribute screen
// store with cursor. Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                              Transfer when
// --------  -----------------------------------  -------------------------
// input     in_valid, in_ready, in_data          in_valid && in_ready
// output    out_valid, out_ready, out_data       out_valid && out_ready
// config    cfg_wr_en, cfg_wr_data               cfg_wr_en (no wait)
//
// Sequence: an ordinary print, backspace, set cursor or unused kind is
//   captured and then executed; a cell read adds a registered store read.
//   Newline finds the row start by stepping one row per cycle. Clear sweeps
//   the store one cell per cycle; a scroll copies every row but the top one
//   up by one row and then blanks the bottom row.
// Reset: after arst_n releases, a blanking pass writes every cell with
//   in_ready low; config writes are taken meanwhile.
// Stalls: a finished result sits in the output register, and the next
//   item is taken while it waits; a second result waits for the first.

module text_console_writer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire tcw_pkg::in_item_t in_data,
	output logic               out_valid,
	input  wire logic          out_ready,
	output tcw_pkg::out_item_t out_data,
	input  wire logic          cfg_wr_en,
	input  wire logic [7:0]    cfg_wr_data
);

	// Command and status between sequencer and datapath
	tcw_pkg::ctl_cmd_t  cmd;
	tcw_pkg::ctl_stat_t stat;

	tcw_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Store, cursor, sweep counter and result register live here
	tcw_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.in_data     (in_data),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_data    (out_data)
	);

endmodule

`default_nettype wire
